@@ rtl/ntuple_value_table_tc_learn_defines.svh @@
// Assertion macros for the n-tuple value table.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef NTUPLE_VALUE_TABLE_TC_LEARN_DEFINES_SVH
`define NTUPLE_VALUE_TABLE_TC_LEARN_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NTV_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define NTV_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define NTV_ASSERT_IMP(label, clk, rst_n, a, b)
`define NTV_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/ntv_pkg.sv @@
// Package for the n-tuple value table: types, codes and cell maps.
// No dependencies.
package ntv_pkg;
    typedef enum logic [1:0] {
        OP_EVAL = 2'd0,
        OP_UPDATE = 2'd1,
        OP_SET = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADDR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_RESULT,
        ST_UPD_RD,
        ST_UPD_CALC,
        ST_UPD_MUL,
        ST_UPD_DIV,
        ST_UPD_WR,
        ST_SET_WR
    } state_t;

    localparam int unsigned IDX_W = 16;
    localparam int unsigned DEPTH = 65536;
    // Tile levels per cell; the table address packs one 4-bit level per element.
    localparam int unsigned TILE_LEVELS = 16;

    // Clockwise quarter turn of a cell position.
    function automatic logic [3:0] turn_cw(input logic [3:0] c);
        logic [1:0] r;
        logic [1:0] k;
        r = c[3:2];
        k = c[1:0];
        return {k, 2'd3 - r};
    endfunction

    // Cell position for one element under symmetry s.
    function automatic logic [3:0] sym_cell(input logic [3:0] c, input logic [2:0] s);
        logic [3:0] x;
        x = c;
        if (s[2])
        begin
            x = {2'd3 - c[3:2], c[1:0]};
        end
        if (s[1:0] >= 2'd1) x = turn_cw(x);
        if (s[1:0] >= 2'd2) x = turn_cw(x);
        if (s[1:0] == 2'd3) x = turn_cw(x);
        return x;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'sh7fffffff;
        if (v < -34'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

@@ rtl/ntv_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module ntv_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Read before write: a write returns the old contents; read data registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/ntv_div.sv @@
// Restoring divider, one quotient bit per cycle, for the learning step.
// Depends on nothing; unsigned 64 by 31 bit, truncating.
module ntv_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [30:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] q_reg, q_next;
    logic [31:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [31:0] trial;

    // One shift-subtract step per cycle.
    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[30:0], q_reg[63]};
        if (start)
        begin
            q_next = dividend;
            rem_next = '0;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
    end

    assign done = busy_reg && (cnt_reg == 7'd1);
    assign quotient = q_next;
endmodule

@@ rtl/ntuple_value_table_tc_learn.sv @@
// N-tuple value table with temporal-coherence learning, top level.
// Uses ntv_pkg, ntv_ram, ntv_div and the assertion macro header.
//
// A request is taken when start is high and busy is low; each request gives
// one value strobed by done for one cycle, and the receiver cannot stall it.
// After reset the block sweeps all 65536 table entries once with busy high.
// An evaluate first forms the eight symmetric table addresses, then reads
// and accumulates the entry at each address in turn on the single table
// port, and ends in the result state in which done strobes the value.
// A set adds a write of the new weight. An update adds one pass per symmetric
// address: read, accumulate, multiply, the one-bit-per-cycle divider and
// the write-back, with busy high throughout.
`include "ntuple_value_table_tc_learn_defines.svh"
module ntuple_value_table_tc_learn (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic [1:0]         operation,
    input  logic [63:0]        board,
    input  logic [2:0]         symmetry,
    input  logic signed [31:0] new_weight,
    input  logic signed [31:0] error,
    output logic signed [34:0] value
);
    import ntv_pkg::*;

    localparam logic [3:0] LVL_MAX = 4'(TILE_LEVELS - 1);

    state_t state_reg, state_next;
    logic [3:0]  cell_reg [4];
    logic [1:0]  op_reg;
    logic [63:0] board_reg;
    logic [2:0]  sym_reg;
    logic signed [31:0] nw_reg, err_reg;
    logic [15:0] addr_reg [8];
    logic [2:0]  i_reg, i_next;
    logic [15:0] clr_reg;
    logic signed [34:0] sum_reg;
    logic signed [31:0] w_reg, n_reg, a_reg;
    logic        neg_reg;
    logic        done_reg;

    logic [15:0] ram_addr;
    logic        ram_we;
    logic        acc_we;
    logic [31:0] w_wd, s_wd, a_wd;
    logic [31:0] w_rd, s_rd, a_rd;
    logic [63:0] acc_wd, acc_rd;
    logic        div_start, div_done;
    logic [63:0] div_q;
    logic [63:0] prod;
    logic [15:0] cur_addr;
    logic [31:0] aerr;
    logic [31:0] an_abs;
    logic signed [31:0] a_new, n_new, w_new;
    logic signed [64:0] dq;

    // Weight table, and the two error sums side by side in a second memory.
    ntv_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_w (.clk, .we(ram_we), .addr(ram_addr),
        .wdata(w_wd), .rdata(w_rd));
    ntv_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_acc (.clk, .we(acc_we), .addr(ram_addr),
        .wdata(acc_wd), .rdata(acc_rd));

    assign acc_wd = {s_wd, a_wd};
    assign s_rd = acc_rd[63:32];
    assign a_rd = acc_rd[31:0];

    ntv_div u_div (.clk, .rst_n, .start(div_start), .dividend(prod),
        .divisor(a_reg[30:0]), .done(div_done), .quotient(div_q));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        unique case (state_reg)
            ST_CLEAR:    if (clr_reg == 16'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:     if (start) state_next = ST_ADDR;
            ST_ADDR:
            begin
                state_next = ST_SUM_RD;
                i_next = 3'd0;
            end
            ST_SUM_RD:   state_next = ST_SUM_ACC;
            ST_SUM_ACC:
            begin
                i_next = i_reg + 3'd1;
                state_next = (i_reg == 3'd7) ? ST_RESULT : ST_SUM_RD;
            end
            ST_RESULT:
            begin
                i_next = 3'd0;
                unique case (op_t'(op_reg))
                    OP_UPDATE: state_next = ST_UPD_RD;
                    OP_SET:    state_next = ST_SET_WR;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_UPD_RD:   state_next = ST_UPD_CALC;
            ST_UPD_CALC: state_next = ST_UPD_MUL;
            ST_UPD_MUL:  state_next = ST_UPD_DIV;
            ST_UPD_DIV:  if (div_done || !(a_reg > 32'sd0)) state_next = ST_UPD_WR;
            ST_UPD_WR:
            begin
                i_next = i_reg + 3'd1;
                state_next = (i_reg == 3'd7) ? ST_IDLE : ST_UPD_RD;
            end
            ST_SET_WR:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Update arithmetic on the entry just read.
    always_comb
    begin
        aerr = err_reg[31] ? 32'(-{err_reg[31], err_reg}) : err_reg;
        a_new = sat32(34'(a_rd) + 34'(signed'({1'b0, aerr})));
        n_new = sat32(34'(signed'(s_rd)) + 34'(err_reg));
        an_abs = n_reg[31] ? 32'(-{n_reg[31], n_reg}) : n_reg;
        prod = 64'(aerr) * 64'(an_abs);
        dq = neg_reg ? -{1'b0, div_q} : {1'b0, div_q};
        if (dq > 65'sd4294967295 || dq < -65'sd4294967296) dq = 65'sd0;
        w_new = sat32((a_reg > 0) ? (34'(w_reg) + 34'(dq)) : 34'(w_reg));
    end

    // Memory port control.
    always_comb
    begin
        cur_addr = (state_reg == ST_SET_WR) ? addr_reg[sym_reg] : addr_reg[i_reg];
        ram_addr = cur_addr;
        ram_we = 1'b0;
        acc_we = 1'b0;
        w_wd = w_new;
        s_wd = n_reg;
        a_wd = a_reg;
        div_start = (state_reg == ST_UPD_MUL) && (a_reg > 0);
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_addr = clr_reg;
                ram_we = 1'b1;
                acc_we = 1'b1;
                w_wd = '0;
                s_wd = 32'd1;
                a_wd = 32'd1;
            end
            ST_UPD_WR:
            begin
                ram_we = 1'b1;
                acc_we = 1'b1;
            end
            ST_SET_WR:
            begin
                ram_we = 1'b1;
                w_wd = nw_reg;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            i_reg <= '0;
            done_reg <= 1'b0;
            cell_reg[0] <= 4'd0;
            cell_reg[1] <= 4'd1;
            cell_reg[2] <= 4'd2;
            cell_reg[3] <= 4'd3;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            done_reg <= (state_reg == ST_SUM_ACC) && (i_reg == 3'd7);
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 16'd1;
            if (cfg_we) cell_reg[cfg_index] <= cfg_data;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            op_reg <= operation;
            board_reg <= board;
            sym_reg <= symmetry;
            nw_reg <= new_weight;
            err_reg <= error;
        end
        if (state_reg == ST_ADDR)
        begin
            for (int s = 0; s < 8; s++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    logic [3:0] c;
                    logic [3:0] l;
                    c = sym_cell(cell_reg[j], 3'(s));
                    l = board_reg[4*c +: 4];
                    if (l > LVL_MAX) l = LVL_MAX;
                    addr_reg[s][4*j +: 4] <= l;
                end
            end
            sum_reg <= '0;
        end
        if (state_reg == ST_SUM_ACC) sum_reg <= sum_reg + 35'(signed'(w_rd));
        if (state_reg == ST_UPD_CALC)
        begin
            a_reg <= a_new;
            n_reg <= n_new;
            w_reg <= w_rd;
            neg_reg <= err_reg[31];
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign value = sum_reg;

    `NTV_ASSERT_IMP(a_no_we_idle, clk, rst_n, state_reg == ST_IDLE, !ram_we)
    `NTV_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)
    `NTV_ASSERT_IMP(a_done_busy, clk, rst_n, done, state_reg == ST_RESULT)
    `NTV_ASSERT_IMP(a_acc_we, clk, rst_n, acc_we, state_reg == ST_CLEAR || state_reg == ST_UPD_WR)
endmodule
